// ----- rtl/core/md5_message_digest_defines.svh -----
// assertion macros shared by the checker
`ifndef MD5_MESSAGE_DIGEST_DEFINES_SVH
`define MD5_MESSAGE_DIGEST_DEFINES_SVH

`define MD5_ASSERT_IMPL(label, clk, rstn, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rstn) (ante) |-> (cons)) \
        else $error(msg);

`define MD5_ASSERT_NEXT(label, clk, rstn, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rstn) (ante) |=> (cons)) \
        else $error(msg);

`endif

// ----- rtl/core/md5_pkg.sv -----
package md5_pkg;

    typedef struct packed {
        logic [31:0] msg_word;
        logic [2:0]  valid_bytes;
        logic        last;
    } md5_in_t;

    typedef struct packed {
        logic [31:0] digest_word;
        logic [1:0]  word_index;
        logic        last_of_digest;
    } md5_out_t;

    // queue entry: word already masked and padded, with its classification
    typedef struct packed {
        logic [31:0] data;
        logic        last;
        logic [2:0]  cnt;
    } md5_cmd_t;

    typedef enum logic [2:0] {
        ST_FILL,
        ST_COMP,
        ST_PADZ,
        ST_LEN_LO,
        ST_LEN_HI,
        ST_OUT
    } md5_state_t;

    localparam logic [31:0] IV_A = 32'h67452301;
    localparam logic [31:0] IV_B = 32'hEFCDAB89;
    localparam logic [31:0] IV_C = 32'h98BADCFE;
    localparam logic [31:0] IV_D = 32'h10325476;
    localparam logic [7:0]  PAD_BYTE = 8'h80;

    function automatic logic [31:0] sine_k(input logic [5:0] i);
        logic [31:0] k;
        case (i)
            6'd0: k = 32'hD76AA478;  6'd1: k = 32'hE8C7B756;
            6'd2: k = 32'h242070DB;  6'd3: k = 32'hC1BDCEEE;
            6'd4: k = 32'hF57C0FAF;  6'd5: k = 32'h4787C62A;
            6'd6: k = 32'hA8304613;  6'd7: k = 32'hFD469501;
            6'd8: k = 32'h698098D8;  6'd9: k = 32'h8B44F7AF;
            6'd10: k = 32'hFFFF5BB1; 6'd11: k = 32'h895CD7BE;
            6'd12: k = 32'h6B901122; 6'd13: k = 32'hFD987193;
            6'd14: k = 32'hA679438E; 6'd15: k = 32'h49B40821;
            6'd16: k = 32'hF61E2562; 6'd17: k = 32'hC040B340;
            6'd18: k = 32'h265E5A51; 6'd19: k = 32'hE9B6C7AA;
            6'd20: k = 32'hD62F105D; 6'd21: k = 32'h02441453;
            6'd22: k = 32'hD8A1E681; 6'd23: k = 32'hE7D3FBC8;
            6'd24: k = 32'h21E1CDE6; 6'd25: k = 32'hC33707D6;
            6'd26: k = 32'hF4D50D87; 6'd27: k = 32'h455A14ED;
            6'd28: k = 32'hA9E3E905; 6'd29: k = 32'hFCEFA3F8;
            6'd30: k = 32'h676F02D9; 6'd31: k = 32'h8D2A4C8A;
            6'd32: k = 32'hFFFA3942; 6'd33: k = 32'h8771F681;
            6'd34: k = 32'h6D9D6122; 6'd35: k = 32'hFDE5380C;
            6'd36: k = 32'hA4BEEA44; 6'd37: k = 32'h4BDECFA9;
            6'd38: k = 32'hF6BB4B60; 6'd39: k = 32'hBEBFBC70;
            6'd40: k = 32'h289B7EC6; 6'd41: k = 32'hEAA127FA;
            6'd42: k = 32'hD4EF3085; 6'd43: k = 32'h04881D05;
            6'd44: k = 32'hD9D4D039; 6'd45: k = 32'hE6DB99E5;
            6'd46: k = 32'h1FA27CF8; 6'd47: k = 32'hC4AC5665;
            6'd48: k = 32'hF4292244; 6'd49: k = 32'h432AFF97;
            6'd50: k = 32'hAB9423A7; 6'd51: k = 32'hFC93A039;
            6'd52: k = 32'h655B59C3; 6'd53: k = 32'h8F0CCC92;
            6'd54: k = 32'hFFEFF47D; 6'd55: k = 32'h85845DD1;
            6'd56: k = 32'h6FA87E4F; 6'd57: k = 32'hFE2CE6E0;
            6'd58: k = 32'hA3014314; 6'd59: k = 32'h4E0811A1;
            6'd60: k = 32'hF7537E82; 6'd61: k = 32'hBD3AF235;
            6'd62: k = 32'h2AD7D2BB; default: k = 32'hEB86D391;
        endcase
        return k;
    endfunction

    function automatic logic [4:0] rot_amt(input logic [5:0] i);
        logic [4:0] r;
        case ({i[5:4], i[1:0]})
            4'd0: r = 5'd7;   4'd1: r = 5'd12;  4'd2: r = 5'd17;  4'd3: r = 5'd22;
            4'd4: r = 5'd5;   4'd5: r = 5'd9;   4'd6: r = 5'd14;  4'd7: r = 5'd20;
            4'd8: r = 5'd4;   4'd9: r = 5'd11;  4'd10: r = 5'd16; 4'd11: r = 5'd23;
            4'd12: r = 5'd6;  4'd13: r = 5'd10; 4'd14: r = 5'd15; default: r = 5'd21;
        endcase
        return r;
    endfunction

endpackage

// ----- rtl/core/md5_front.sv -----
module md5_front import md5_pkg::*; (
    input  logic     aclk,
    input  logic     aresetn,
    input  logic     s_valid,
    output logic     s_ready,
    input  md5_in_t  s_data,
    output logic     q_valid,
    input  logic     q_ready,
    output md5_cmd_t q_data
);
    // two-entry queue of classified words
    md5_cmd_t    mem_reg [2];
    logic        wptr_reg, wptr_next, rptr_reg, rptr_next;
    logic [1:0]  cnt_reg, cnt_next;
    md5_cmd_t    cmd;
    logic [2:0]  nb;
    logic [31:0] keep;
    logic        push, pop;

    always_comb begin
        nb = (s_data.valid_bytes > 3'd4 || !s_data.last) ? 3'd4 : s_data.valid_bytes;
        case (nb)
            3'd0: keep = 32'h0000_0000;
            3'd1: keep = 32'h0000_00FF;
            3'd2: keep = 32'h0000_FFFF;
            3'd3: keep = 32'h00FF_FFFF;
            default: keep = 32'hFFFF_FFFF;
        endcase
        cmd.data = s_data.msg_word & keep;
        case (nb)
            3'd0: cmd.data[7:0]   = PAD_BYTE;
            3'd1: cmd.data[15:8]  = PAD_BYTE;
            3'd2: cmd.data[23:16] = PAD_BYTE;
            3'd3: cmd.data[31:24] = PAD_BYTE;
            default: ;
        endcase
        cmd.last = s_data.last;
        cmd.cnt  = nb;
    end

    assign s_ready = (cnt_reg != 2'd2);
    assign push    = s_valid && s_ready;
    assign q_valid = (cnt_reg != 2'd0);
    assign pop     = q_valid && q_ready;
    assign q_data  = mem_reg[rptr_reg];

    always_comb begin
        wptr_next = push ? ~wptr_reg : wptr_reg;
        rptr_next = pop ? ~rptr_reg : rptr_reg;
        cnt_next  = cnt_reg + {1'b0, push} - {1'b0, pop};
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            wptr_reg <= 1'b0;
            rptr_reg <= 1'b0;
            cnt_reg  <= 2'd0;
        end else begin
            wptr_reg <= wptr_next;
            rptr_reg <= rptr_next;
            cnt_reg  <= cnt_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (push) begin
            mem_reg[wptr_reg] <= cmd;
        end
    end
endmodule

// ----- rtl/core/md5_back.sv -----
module md5_back import md5_pkg::*; (
    input  logic     aclk,
    input  logic     aresetn,
    input  logic     q_valid,
    output logic     q_ready,
    input  md5_cmd_t q_data,
    output logic     m_valid,
    input  logic     m_ready,
    output md5_out_t m_data
);
    md5_state_t  state_reg, state_next;
    logic [31:0] buf_reg [16];
    logic [31:0] cv_reg [4];
    logic [31:0] a_reg, b_reg, c_reg, d_reg;
    logic [3:0]  pos_reg, pos_next;
    logic [5:0]  rnd_reg;
    logic [60:0] total_reg, total_next;
    logic        fin_reg;      // current block is the length block
    logic        more_reg;     // last word taken, padding still in progress
    logic        pad_reg;      // next padding slot takes the pad byte
    logic [1:0]  oidx_reg;
    logic        outv_reg;

    // buffer write port
    logic        bw_en;
    logic [3:0]  bw_addr;
    logic [31:0] bw_data;
    logic        comp_start, comp_done;
    logic [63:0] bits;

    logic [3:0]  sel;
    logic [31:0] f, t, rot;

    assign bits = {total_reg, 3'b000};

    always_comb begin
        case (rnd_reg[5:4])
            2'd0: begin
                f = (b_reg & c_reg) | (~b_reg & d_reg);
                sel = rnd_reg[3:0];
            end
            2'd1: begin
                f = (b_reg & d_reg) | (c_reg & ~d_reg);
                sel = 4'(5 * rnd_reg[3:0] + 1);
            end
            2'd2: begin
                f = b_reg ^ c_reg ^ d_reg;
                sel = 4'(3 * rnd_reg[3:0] + 5);
            end
            default: begin
                f = c_reg ^ (b_reg | ~d_reg);
                sel = 4'(7 * rnd_reg[3:0]);
            end
        endcase
        t   = a_reg + f + buf_reg[sel] + sine_k(rnd_reg);
        rot = (t << rot_amt(rnd_reg)) | (t >> (6'd32 - {1'b0, rot_amt(rnd_reg)}));
    end

    assign comp_done = (state_reg == ST_COMP) && (rnd_reg == 6'd63);

    always_comb begin
        state_next = state_reg;
        pos_next   = pos_reg;
        total_next = total_reg;
        q_ready    = 1'b0;
        bw_en      = 1'b0;
        bw_addr    = pos_reg;
        bw_data    = q_data.data;
        comp_start = 1'b0;
        case (state_reg)
            ST_FILL: begin
                q_ready = 1'b1;
                if (q_valid) begin
                    bw_en      = 1'b1;
                    total_next = total_reg + 61'(q_data.cnt);
                    pos_next   = pos_reg + 4'd1;
                    if (pos_reg == 4'd15) begin
                        comp_start = 1'b1;
                        state_next = ST_COMP;
                    end else if (q_data.last) begin
                        state_next = ST_PADZ;
                    end
                end
            end
            ST_COMP: begin
                if (comp_done) begin
                    if (fin_reg) begin
                        state_next = ST_OUT;
                    end else if (more_reg) begin
                        state_next = ST_PADZ;
                    end else begin
                        state_next = ST_FILL;
                    end
                end
            end
            ST_PADZ: begin
                // pos_reg names the next slot to fill with zero or the pad byte
                if (pos_reg == 4'd14 && !pad_reg) begin
                    state_next = ST_LEN_LO;
                end else begin
                    bw_en    = 1'b1;
                    bw_data  = pad_reg ? {24'd0, PAD_BYTE} : 32'd0;
                    pos_next = pos_reg + 4'd1;
                    if (pos_reg == 4'd15) begin
                        comp_start = 1'b1;
                        state_next = ST_COMP;
                    end
                end
            end
            ST_LEN_LO: begin
                bw_en    = 1'b1;
                bw_addr  = 4'd14;
                bw_data  = bits[31:0];
                state_next = ST_LEN_HI;
            end
            ST_LEN_HI: begin
                bw_en      = 1'b1;
                bw_addr    = 4'd15;
                bw_data    = bits[63:32];
                comp_start = 1'b1;
                state_next = ST_COMP;
            end
            ST_OUT: begin
                if (m_ready && oidx_reg == 2'd3) begin
                    state_next = ST_FILL;
                    pos_next   = 4'd0;
                    total_next = '0;
                end
            end
            default: state_next = ST_FILL;
        endcase
    end

    assign m_valid = outv_reg;
    assign m_data.digest_word    = cv_reg[oidx_reg];
    assign m_data.word_index     = oidx_reg;
    assign m_data.last_of_digest = (oidx_reg == 2'd3);

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= ST_FILL;
            pos_reg   <= '0;
            total_reg <= '0;
            rnd_reg   <= '0;
            fin_reg   <= 1'b0;
            more_reg  <= 1'b0;
            pad_reg   <= 1'b0;
            oidx_reg  <= '0;
            outv_reg  <= 1'b0;
            cv_reg[0] <= IV_A;
            cv_reg[1] <= IV_B;
            cv_reg[2] <= IV_C;
            cv_reg[3] <= IV_D;
        end else begin
            state_reg <= state_next;
            pos_reg   <= pos_next;
            total_reg <= total_next;
            if (comp_start) begin
                rnd_reg <= '0;
            end else if (state_reg == ST_COMP) begin
                rnd_reg <= rnd_reg + 6'd1;
            end
            // a full last word leaves the pad byte to the first padding slot
            if (state_reg == ST_FILL && q_valid && q_data.last) begin
                more_reg <= 1'b1;
                pad_reg  <= (q_data.cnt == 3'd4);
            end else if (state_reg == ST_PADZ && !(pos_reg == 4'd14 && !pad_reg)) begin
                pad_reg <= 1'b0;
            end else if (state_reg == ST_LEN_HI) begin
                more_reg <= 1'b0;
                fin_reg  <= 1'b1;
            end
            if (comp_done) begin
                cv_reg[0] <= cv_reg[0] + d_reg;
                cv_reg[1] <= cv_reg[1] + (b_reg + rot);
                cv_reg[2] <= cv_reg[2] + b_reg;
                cv_reg[3] <= cv_reg[3] + c_reg;
                if (fin_reg) begin
                    outv_reg <= 1'b1;
                    oidx_reg <= '0;
                end
            end
            if (outv_reg && m_ready) begin
                oidx_reg <= oidx_reg + 2'd1;
                if (oidx_reg == 2'd3) begin
                    outv_reg  <= 1'b0;
                    fin_reg   <= 1'b0;
                    cv_reg[0] <= IV_A;
                    cv_reg[1] <= IV_B;
                    cv_reg[2] <= IV_C;
                    cv_reg[3] <= IV_D;
                end
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (bw_en) begin
            buf_reg[bw_addr] <= bw_data;
        end
        if (comp_start) begin
            a_reg <= cv_reg[0];
            b_reg <= cv_reg[1];
            c_reg <= cv_reg[2];
            d_reg <= cv_reg[3];
        end else if (state_reg == ST_COMP) begin
            a_reg <= d_reg;
            d_reg <= c_reg;
            c_reg <= b_reg;
            b_reg <= b_reg + rot;
        end
    end
endmodule

// ----- rtl/core/md5_message_digest.sv -----
// the single round unit (one md5 step per cycle) limits the input rate; while a block
// is compressed, no words are taken from the front queue
// a last word passes through the front queue, then zero fill and the length words, one
// or two compressions and four output transactions
// synchronous active-low reset returns the chaining value to the initial vector
module md5_message_digest import md5_pkg::*; (
    input  logic     aclk,
    input  logic     aresetn,
    input  logic     s_valid,
    output logic     s_ready,
    input  md5_in_t  s_data,
    output logic     m_valid,
    input  logic     m_ready,
    output md5_out_t m_data
);
    logic     q_valid, q_ready;
    md5_cmd_t q_data;

    md5_front u_front (
        .aclk(aclk), .aresetn(aresetn),
        .s_valid(s_valid), .s_ready(s_ready), .s_data(s_data),
        .q_valid(q_valid), .q_ready(q_ready), .q_data(q_data)
    );

    md5_back u_back (
        .aclk(aclk), .aresetn(aresetn),
        .q_valid(q_valid), .q_ready(q_ready), .q_data(q_data),
        .m_valid(m_valid), .m_ready(m_ready), .m_data(m_data)
    );
endmodule

// ----- rtl/core/md5_checker.sv -----
`include "md5_message_digest_defines.svh"
module md5_checker import md5_pkg::*; (
    input logic     aclk,
    input logic     aresetn,
    input logic     s_valid,
    input logic     s_ready,
    input logic     m_valid,
    input logic     m_ready,
    input md5_out_t m_data
);
    `MD5_ASSERT_NEXT(a_s_hold, aclk, aresetn, s_valid && !s_ready, s_valid, "input dropped before transaction")
    `MD5_ASSERT_NEXT(a_m_hold, aclk, aresetn, m_valid && !m_ready, m_valid && $stable(m_data), "result changed while stalled")
    `MD5_ASSERT_NEXT(a_idx_step, aclk, aresetn, m_valid && m_ready && m_data.word_index != 2'd3, m_valid && m_data.word_index == $past(m_data.word_index) + 2'd1, "digest words not consecutive")
    `MD5_ASSERT_IMPL(a_last_flag, aclk, aresetn, m_valid, m_data.last_of_digest == (m_data.word_index == 2'd3), "last flag mismatch")
    `MD5_ASSERT_NEXT(a_gap, aclk, aresetn, m_valid && m_ready && m_data.last_of_digest, !m_valid, "digest words after the fourth")
endmodule

bind md5_message_digest md5_checker u_checker (
    .aclk(aclk), .aresetn(aresetn),
    .s_valid(s_valid), .s_ready(s_ready),
    .m_valid(m_valid), .m_ready(m_ready), .m_data(m_data)
);

// ----- dv/md5_message_digest_test.sv -----
module md5_message_digest_test import md5_pkg::*; ();
    timeunit 1ns;
    timeprecision 1ps;

    localparam int unsigned CYCLE_LIMIT = 400000;
    localparam int unsigned DRAIN_CYCLES = 200;

    logic     aclk = 1'b0;
    logic     aresetn = 1'b0;
    logic     s_valid = 1'b0;
    logic     s_ready;
    md5_in_t  s_data = '0;
    logic     m_valid;
    logic     m_ready = 1'b0;
    md5_out_t m_data;

    md5_message_digest dut (
        .aclk(aclk), .aresetn(aresetn),
        .s_valid(s_valid), .s_ready(s_ready), .s_data(s_data),
        .m_valid(m_valid), .m_ready(m_ready), .m_data(m_data)
    );

    always begin
        #2 aclk = 1'b1;
        #2 aclk = 1'b0;
    end

    // predictor state
    logic [31:0] chain_q [4];
    logic [31:0] blk_words [16];
    logic [60:0] msg_bytes;
    md5_out_t    digest_q [$];

    int unsigned fail_count = 0;
    int unsigned cycle_count = 0;
    bit          idle_on = 1'b1;
    bit          hold_sink = 1'b0;

    const logic [31:0] sine_k_tab [64] = '{
        32'hD76AA478, 32'hE8C7B756, 32'h242070DB, 32'hC1BDCEEE,
        32'hF57C0FAF, 32'h4787C62A, 32'hA8304613, 32'hFD469501,
        32'h698098D8, 32'h8B44F7AF, 32'hFFFF5BB1, 32'h895CD7BE,
        32'h6B901122, 32'hFD987193, 32'hA679438E, 32'h49B40821,
        32'hF61E2562, 32'hC040B340, 32'h265E5A51, 32'hE9B6C7AA,
        32'hD62F105D, 32'h02441453, 32'hD8A1E681, 32'hE7D3FBC8,
        32'h21E1CDE6, 32'hC33707D6, 32'hF4D50D87, 32'h455A14ED,
        32'hA9E3E905, 32'hFCEFA3F8, 32'h676F02D9, 32'h8D2A4C8A,
        32'hFFFA3942, 32'h8771F681, 32'h6D9D6122, 32'hFDE5380C,
        32'hA4BEEA44, 32'h4BDECFA9, 32'hF6BB4B60, 32'hBEBFBC70,
        32'h289B7EC6, 32'hEAA127FA, 32'hD4EF3085, 32'h04881D05,
        32'hD9D4D039, 32'hE6DB99E5, 32'h1FA27CF8, 32'hC4AC5665,
        32'hF4292244, 32'h432AFF97, 32'hAB9423A7, 32'hFC93A039,
        32'h655B59C3, 32'h8F0CCC92, 32'hFFEFF47D, 32'h85845DD1,
        32'h6FA87E4F, 32'hFE2CE6E0, 32'hA3014314, 32'h4E0811A1,
        32'hF7537E82, 32'hBD3AF235, 32'h2AD7D2BB, 32'hEB86D391
    };
    const int unsigned shift_tab [16] = '{7, 12, 17, 22, 5, 9, 14, 20,
                                          4, 11, 16, 23, 6, 10, 15, 21};

    function automatic void load_init_chain();
        chain_q[0] = 32'h67452301;
        chain_q[1] = 32'hEFCDAB89;
        chain_q[2] = 32'h98BADCFE;
        chain_q[3] = 32'h10325476;
    endfunction

    function automatic void run_rounds();
        logic [31:0] a, b, c, d, f, t;
        int unsigned grp, sel, sh;
        a = chain_q[0]; b = chain_q[1]; c = chain_q[2]; d = chain_q[3];
        for (int unsigned i = 0; i < 64; i++) begin
            grp = i / 16;
            case (grp)
                0: begin f = (b & c) | (~b & d); sel = i; end
                1: begin f = (b & d) | (c & ~d); sel = 5 * i + 1; end
                2: begin f = b ^ c ^ d; sel = 3 * i + 5; end
                default: begin f = c ^ (b | ~d); sel = 7 * i; end
            endcase
            t = a + f + blk_words[sel % 16] + sine_k_tab[i];
            sh = shift_tab[grp * 4 + i % 4];
            t = b + ((t << sh) | (t >> (32 - sh)));
            a = d; d = c; c = b; b = t;
        end
        chain_q[0] += a; chain_q[1] += b; chain_q[2] += c; chain_q[3] += d;
    endfunction

    function automatic void absorb_word(md5_in_t item);
        int unsigned pos, cnt;
        logic [31:0] keep;
        logic [63:0] bit_len;
        md5_out_t r;
        pos = msg_bytes[5:2];
        cnt = (item.valid_bytes > 4) ? 4 : item.valid_bytes;
        if (!item.last) begin
            blk_words[pos] = item.msg_word;
            msg_bytes += 4;
            if (pos == 15) run_rounds();
            return;
        end
        msg_bytes += cnt;
        if (cnt == 4) begin
            blk_words[pos] = item.msg_word;
            if (pos == 15) begin
                run_rounds();
                pos = 0;
            end else begin
                pos++;
            end
            blk_words[pos] = 32'h80;
        end else begin
            keep = (cnt == 0) ? 32'h0 : (32'hFFFFFFFF >> (8 * (4 - cnt)));
            blk_words[pos] = (item.msg_word & keep) | (32'h80 << (8 * cnt));
        end
        if (pos >= 14) begin
            for (int unsigned i = pos + 1; i < 16; i++) blk_words[i] = '0;
            run_rounds();
            for (int unsigned i = 0; i < 14; i++) blk_words[i] = '0;
        end else begin
            for (int unsigned i = pos + 1; i < 14; i++) blk_words[i] = '0;
        end
        bit_len = {msg_bytes, 3'b000};
        blk_words[14] = bit_len[31:0];
        blk_words[15] = bit_len[63:32];
        run_rounds();
        for (int unsigned i = 0; i < 4; i++) begin
            r.digest_word = chain_q[i];
            r.word_index = i[1:0];
            r.last_of_digest = (i == 3);
            digest_q.push_back(r);
        end
        load_init_chain();
        msg_bytes = '0;
    endfunction

    // valid stays high between back-to-back transactions; idle gaps drop it
    task automatic send_word(input logic [31:0] w, input logic [2:0] vb, input logic lst);
        md5_in_t item;
        int unsigned gap;
        if (idle_on && $urandom_range(0, 3) == 0) begin
            gap = $urandom_range(1, 5);
            s_valid <= 1'b0;
            repeat (gap) @(posedge aclk);
        end
        item.msg_word = w;
        item.valid_bytes = vb;
        item.last = lst;
        s_valid <= 1'b1;
        s_data <= item;
        do @(posedge aclk); while (!s_ready);
        absorb_word(item);
    endtask

    task automatic send_message(input int unsigned nfull, input logic [2:0] last_vb);
        for (int unsigned i = 0; i < nfull; i++)
            send_word($urandom, 3'($urandom), 1'b0);
        send_word($urandom, last_vb, 1'b1);
    endtask

    task automatic wait_digests_drained();
        s_valid <= 1'b0;
        while (digest_q.size() != 0) @(posedge aclk);
    endtask

    // receiver side
    always @(posedge aclk) begin
        if (aresetn) begin
            if (m_valid && m_ready) begin
                if (digest_q.size() == 0) begin
                    $error("unexpected digest transaction %h", m_data);
                    fail_count++;
                end else begin
                    md5_out_t exp_r;
                    exp_r = digest_q.pop_front();
                    if (m_data.digest_word !== exp_r.digest_word) begin
                        $error("digest_word expected %h actual %h",
                               exp_r.digest_word, m_data.digest_word);
                        fail_count++;
                    end
                    if (m_data.word_index !== exp_r.word_index) begin
                        $error("word_index expected %0d actual %0d",
                               exp_r.word_index, m_data.word_index);
                        fail_count++;
                    end
                    if (m_data.last_of_digest !== exp_r.last_of_digest) begin
                        $error("last_of_digest expected %0d actual %0d",
                               exp_r.last_of_digest, m_data.last_of_digest);
                        fail_count++;
                    end
                end
            end
        end
    end

    int unsigned sink_stall = 0;
    always @(posedge aclk) begin
        if (hold_sink) begin
            m_ready <= 1'b0;
        end else if (sink_stall != 0) begin
            sink_stall <= sink_stall - 1;
            m_ready <= 1'b0;
        end else if (idle_on && $urandom_range(0, 3) == 0) begin
            sink_stall <= $urandom_range(0, 4);
            m_ready <= 1'b0;
        end else begin
            m_ready <= 1'b1;
        end
    end

    always @(posedge aclk) begin
        cycle_count++;
        if (cycle_count > CYCLE_LIMIT) begin
            $display("[md5_message_digest] ERROR");
            $finish;
        end
    end

    task automatic test_known_vectors();
        // empty message, "abc", and extremes of the word and byte count
        send_word(32'hFFFFFFFF, 3'd0, 1'b1);
        send_word(32'hFF636261, 3'd3, 1'b1);
        send_word(32'hFFFFFFFF, 3'd4, 1'b1);
        send_word(32'h00000000, 3'd4, 1'b1);
        send_word(32'hA5A5A5A5, 3'd7, 1'b1);
        send_word(32'h5A5A5A5A, 3'd5, 1'b1);
        send_word(32'h12345678, 3'd1, 1'b1);
        send_word(32'h12345678, 3'd2, 1'b1);
    endtask

    task automatic test_block_boundaries();
        // last word landing on positions 13, 14, 15 and after a full block
        send_message(13, 3'd4);
        send_message(14, 3'd2);
        send_message(15, 3'd4);
        send_message(16, 3'd0);
        wait_digests_drained();
    endtask

    task automatic test_output_backpressure();
        int unsigned hold_cycles;
        hold_sink = 1'b1;
        fork
            begin
                hold_cycles = 0;
                while (hold_cycles < 600) begin
                    @(posedge aclk);
                    hold_cycles++;
                end
                hold_sink = 1'b0;
            end
            begin
                send_message(2, 3'd1);
                send_message(3, 3'd4);
                send_message(1, 3'd3);
            end
        join
        wait_digests_drained();
    endtask

    task automatic test_random_messages();
        int unsigned sent;
        sent = 0;
        while (sent < 110) begin
            int unsigned n;
            n = ($urandom_range(0, 9) == 0) ? $urandom_range(17, 40) : $urandom_range(0, 15);
            send_message(n, 3'($urandom));
            sent += n + 1;
        end
        idle_on = 1'b0;
        for (int unsigned i = 0; i < 3; i++) send_message($urandom_range(0, 10), 3'($urandom));
    endtask

    initial begin
        int unsigned tail;
        load_init_chain();
        msg_bytes = '0;
        repeat (3) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);
        test_known_vectors();
        test_block_boundaries();
        test_output_backpressure();
        test_random_messages();
        wait_digests_drained();
        tail = 0;
        while (tail < DRAIN_CYCLES) begin
            @(posedge aclk);
            tail++;
        end
        if (fail_count == 0 && digest_q.size() == 0) begin
            $display("[md5_message_digest] OK");
        end else begin
            $display("[md5_message_digest] ERROR");
        end
        $finish;
    end
endmodule
